>>> rtl/core/salc_pkg.sv
// Shared types and constants of the cache classifier.
package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int WAYS         = 4;
  localparam int ADDR_W       = 48;

  localparam int SET_W   = MAX_SET_BITS;
  localparam int SETS    = 1 << SET_W;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NWAY_W  = $clog2(WAYS + 1);
  localparam int AGE_W   = 3;
  localparam int CNT_W   = 32;
  localparam int MODE_W  = 2;
  localparam int OUTC_W  = 2;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 5;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

  localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

  localparam logic [IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
  } access_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic              extra_hit;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  eviction_total;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
  } cfg_word_t;

endpackage

>>> rtl/core/salc_if.sv
// Handshake channels: access words in, result words out, register writes.
interface salc_acc_if;
  logic               valid;
  logic               ready;
  salc_pkg::access_t  word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface salc_res_if;
  logic               valid;
  logic               ready;
  salc_pkg::result_t  word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface salc_cfg_if;
  logic                 valid;
  logic                 ready;
  salc_pkg::cfg_word_t  word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

>>> rtl/core/set_assoc_lru_cache_classifier_core.sv
// Set-associative LRU cache classifier: one set row per memory entry.
//
//  channel | dir | payload                                   | taken when
//  acc     | in  | mode, address                             | valid & ready
//  res     | out | outcome, extra_hit, hit/miss/evict totals | valid & ready
//  cfg     | in  | index, data                               | valid & ready
//
// Each access reads the set row from the single-port row memory on accept,
// then updates it and writes it back as the result is registered.
// Reset clears counters and one valid flag per set row at once, and returns registers to defaults.
// A result waiting on res holds the update; the next access is accepted
// meanwhile and waits in the lookup state.
module set_assoc_lru_cache_classifier_core (
  input  logic      clk,
  input  logic      rst,
  salc_acc_if.sink  acc,
  salc_res_if.source res,
  salc_cfg_if.sink  cfg
);
  import salc_pkg::*;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][AGE_W-1:0]  age;
    logic [WAYS-1:0][ADDR_W-1:0] tag;
  } row_t;

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t state;

  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [2:0] ways_in_use;

  row_t mem [SETS];
  row_t rd_row;
  logic [SETS-1:0] row_ok;
  logic            rd_ok;

  logic [SET_W-1:0]  cur_set;
  logic [ADDR_W-1:0] cur_tag;
  logic [MODE_W-1:0] cur_mode;

  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] eviction_count;

  logic              out_valid;
  logic [OUTC_W-1:0] out_outcome;
  logic              out_extra;

  logic [SET_W-1:0]  in_set;
  logic [ADDR_W-1:0] in_tag;
  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] set_mask;
  logic [2:0]        s_clamp;
  logic [NWAY_W-1:0] nways;

  row_t              row;
  row_t              row_next;
  logic [WAYS-1:0]   hitv;
  logic [WAYS-1:0]   emptyv;
  logic              found;
  logic              has_empty;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  fill_way;
  logic [WAY_W-1:0]  old_way;
  logic [WAY_W-1:0]  pick;
  logic              was_valid;
  logic [AGE_W-1:0]  pick_age;
  logic [OUTC_W-1:0] outcome_next;
  logic [CNT_W-1:0]  hit_next;
  logic [CNT_W-1:0]  miss_next;
  logic [CNT_W-1:0]  eviction_next;

  logic acc_take;
  logic slot_free;
  logic commit;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign acc.ready = (state == S_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign acc_take  = acc.valid && acc.ready;
  assign slot_free = !out_valid || res.ready;
  assign commit    = (state == S_LOOK) && slot_free;

  assign res.valid               = out_valid;
  assign res.word.outcome        = out_outcome;
  assign res.word.extra_hit      = out_extra;
  assign res.word.hit_total      = hit_count;
  assign res.word.miss_total     = miss_count;
  assign res.word.eviction_total = eviction_count;

  always_comb begin
    s_clamp  = (int'(set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits;
    shifted  = acc.word.address >> block_bits;
    set_mask = ~({ADDR_W{1'b1}} << s_clamp);
    in_set   = SET_W'(shifted & set_mask);
    in_tag   = shifted >> s_clamp;
    if (ways_in_use == 3'd0) begin
      nways = NWAY_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      nways = NWAY_W'(WAYS);
    end else begin
      nways = NWAY_W'(ways_in_use);
    end
  end

  always_comb begin
    row       = rd_ok ? rd_row : '0;
    hitv      = '0;
    emptyv    = '0;
    hit_way   = '0;
    fill_way  = '0;
    old_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (w < int'(nways)) begin
        hitv[w]   = row.valid[w] && (row.tag[w] == cur_tag);
        emptyv[w] = !row.valid[w];
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hit_way = WAY_W'(w);
      end
      if (emptyv[w]) begin
        fill_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (w < int'(nways) && row.age[w] > row.age[old_way]) begin
        old_way = WAY_W'(w);
      end
    end
    found     = |hitv;
    has_empty = |emptyv;
    if (found) begin
      pick         = hit_way;
      outcome_next = OUTC_HIT;
    end else if (has_empty) begin
      pick         = fill_way;
      outcome_next = OUTC_FILL;
    end else begin
      pick         = old_way;
      outcome_next = OUTC_EVICT;
    end
    was_valid = found || !has_empty;
    pick_age  = row.age[pick];

    row_next = row;
    for (int w = 0; w < WAYS; w++) begin
      if (w < int'(nways)) begin
        if (WAY_W'(w) == pick) begin
          row_next.age[w]   = '0;
          row_next.valid[w] = 1'b1;
          row_next.tag[w]   = cur_tag;
        end else if (row.valid[w] && (!was_valid || row.age[w] < pick_age) &&
                     row.age[w] != '1) begin
          row_next.age[w] = row.age[w] + 1'b1;
        end
      end
    end

    hit_next      = found ? sat_inc(hit_count) : hit_count;
    if (cur_mode == MODE_MODIFY) begin
      hit_next = sat_inc(hit_next);
    end
    miss_next     = found ? miss_count : sat_inc(miss_count);
    eviction_next = (outcome_next == OUTC_EVICT) ? sat_inc(eviction_count)
                                                 : eviction_count;
  end

  always_ff @(posedge clk) begin
    if (acc_take) begin
      rd_row <= mem[in_set];
    end
    if (commit) begin
      mem[cur_set] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take) begin
      cur_set  <= in_set;
      cur_tag  <= in_tag;
      cur_mode <= acc.word.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      row_ok         <= '0;
      rd_ok          <= 1'b0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
      set_bits       <= 3'd0;
      block_bits     <= 5'd0;
      ways_in_use    <= 3'd1;
    end else begin
      if (cfg.valid) begin
        case (cfg.word.index)
          REG_SET_BITS:    set_bits    <= cfg.word.data[2:0];
          REG_BLOCK_BITS:  block_bits  <= cfg.word.data;
          REG_WAYS_IN_USE: ways_in_use <= cfg.word.data[2:0];
          default: ;
        endcase
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_take) begin
            rd_ok <= row_ok[in_set];
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (slot_free) begin
            out_outcome     <= outcome_next;
            out_extra       <= (cur_mode == MODE_MODIFY);
            row_ok[cur_set] <= 1'b1;
            hit_count       <= hit_next;
            miss_count      <= miss_next;
            eviction_count  <= eviction_next;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> test/set_assoc_lru_cache_classifier_core_tb.sv
// Self-checking testbench for the set-associative LRU cache classifier core.
module set_assoc_lru_cache_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int LINES = SETS * WAYS;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [AGE_W-1:0] AGE_TOP = '1;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  logic clk;
  logic rst;

  salc_acc_if acc_ch ();
  salc_res_if res_ch ();
  salc_cfg_if cfg_ch ();

  set_assoc_lru_cache_classifier_core dut (
    .clk (clk),
    .rst (rst),
    .acc (acc_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  logic [ADDR_W-1:0] tag_store [LINES];
  bit                valid_store [LINES];
  logic [AGE_W-1:0]  age_rank [LINES];
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  miss_cnt;
  logic [CNT_W-1:0]  evict_cnt;
  logic [2:0]        set_bits_r;
  logic [4:0]        block_bits_r;
  logic [2:0]        ways_r;

  result_t pending_results [$];

  bit calm;
  int hold_left;
  int failures;
  int n_items;
  int n_hit;
  int n_fill;
  int n_evict;
  int n_cfg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void reset_shadow();
    for (int i = 0; i < LINES; i++) begin
      tag_store[i] = '0;
      valid_store[i] = 1'b0;
      age_rank[i] = '0;
    end
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;
    set_bits_r = 3'd0;
    block_bits_r = 5'd0;
    ways_r = 3'd1;
  endfunction

  function automatic int eff_set_bits();
    return (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_r);
  endfunction

  function automatic int eff_ways();
    if (ways_r == 0) return 1;
    return (ways_r > WAYS) ? WAYS : int'(ways_r);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic void promote_line(int base, int nw, int pick, bit was_valid);
    logic [AGE_W-1:0] prev;
    int k;
    prev = age_rank[base + pick];
    for (int w = 0; w < nw; w++) begin
      k = base + w;
      if (w != pick && valid_store[k] && (!was_valid || age_rank[k] < prev) &&
          age_rank[k] != AGE_TOP)
        age_rank[k] = age_rank[k] + 1'b1;
    end
    age_rank[base + pick] = '0;
  endfunction

  function automatic result_t classify_access(logic [MODE_W-1:0] mode,
                                              logic [ADDR_W-1:0] addr);
    result_t r;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] tag;
    int s;
    int nw;
    int base;
    int hit_way;
    int victim;
    s = eff_set_bits();
    nw = eff_ways();
    blk = addr >> block_bits_r;
    tag = blk >> s;
    base = int'(blk & ((48'd1 << s) - 1)) * WAYS;
    hit_way = -1;
    victim = -1;
    for (int w = 0; w < nw; w++) begin
      if (hit_way < 0 && valid_store[base + w] && tag_store[base + w] == tag)
        hit_way = w;
    end
    if (hit_way >= 0) begin
      promote_line(base, nw, hit_way, 1'b1);
      hit_cnt = sat_inc(hit_cnt);
      r.outcome = OUTC_HIT;
      n_hit++;
    end else begin
      miss_cnt = sat_inc(miss_cnt);
      for (int w = 0; w < nw; w++) begin
        if (victim < 0 && !valid_store[base + w]) victim = w;
      end
      if (victim >= 0) begin
        tag_store[base + victim] = tag;
        promote_line(base, nw, victim, 1'b0);
        valid_store[base + victim] = 1'b1;
        r.outcome = OUTC_FILL;
        n_fill++;
      end else begin
        evict_cnt = sat_inc(evict_cnt);
        victim = 0;
        for (int w = 1; w < nw; w++) begin
          if (age_rank[base + w] > age_rank[base + victim]) victim = w;
        end
        tag_store[base + victim] = tag;
        promote_line(base, nw, victim, 1'b1);
        r.outcome = OUTC_EVICT;
        n_evict++;
      end
    end
    if (mode == MODE_MODIFY) hit_cnt = sat_inc(hit_cnt);
    r.extra_hit = (mode == MODE_MODIFY);
    r.hit_total = hit_cnt;
    r.miss_total = miss_cnt;
    r.eviction_total = evict_cnt;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] line_addr(logic [ADDR_W-1:0] tag, int set_idx,
                                                  logic [ADDR_W-1:0] off);
    int s;
    s = eff_set_bits();
    return (tag << (block_bits_r + s)) | (ADDR_W'(set_idx) << block_bits_r) | off;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: unexpected result outcome=%0d extra=%0b hits=%0d misses=%0d evicts=%0d",
                 $realtime, got.outcome, got.extra_hit, got.hit_total, got.miss_total,
                 got.eviction_total);
    end else begin
      want = pending_results.pop_front();
      if (got.outcome !== want.outcome || got.extra_hit !== want.extra_hit ||
          got.hit_total !== want.hit_total || got.miss_total !== want.miss_total ||
          got.eviction_total !== want.eviction_total) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch exp outcome=%0d extra=%0b hits=%0d misses=%0d evicts=%0d %s",
                   $realtime, want.outcome, want.extra_hit, want.hit_total,
                   want.miss_total, want.eviction_total,
                   $sformatf("got outcome=%0d extra=%0b hits=%0d misses=%0d evicts=%0d",
                             got.outcome, got.extra_hit, got.hit_total, got.miss_total,
                             got.eviction_total));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_result(res_ch.word);
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic send_access(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr);
    int gap;
    gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      acc_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    acc_ch.valid <= 1'b1;
    acc_ch.word <= access_t'{mode: mode, address: addr};
    do @(posedge clk); while (!acc_ch.ready);
    pending_results.push_back(classify_access(mode, addr));
    n_items++;
  endtask

  task automatic finish_burst();
    acc_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.word <= cfg_word_t'{index: idx, data: data};
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SET_BITS:    set_bits_r = data[2:0];
      REG_BLOCK_BITS:  block_bits_r = data;
      REG_WAYS_IN_USE: ways_r = data[2:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_geometry(logic [DATA_W-1:0] sb, logic [DATA_W-1:0] bb,
                              logic [DATA_W-1:0] wu);
    cfg_write(REG_SET_BITS, sb);
    cfg_write(REG_BLOCK_BITS, bb);
    cfg_write(REG_WAYS_IN_USE, wu);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_access(MODE_LOAD, '0);
    send_access(MODE_STORE, '1);
    send_access(MODE_MODIFY, '1);
    send_access(MODE_SPARE, '0);
    finish_burst();
  endtask

  task automatic test_lru_order();
    set_geometry(5'd2, 5'd4, 5'd4);
    send_access(MODE_LOAD, line_addr(48'd1, 1, 48'd3));
    send_access(MODE_STORE, line_addr(48'd2, 1, 48'd0));
    send_access(MODE_MODIFY, line_addr(48'd3, 1, 48'd15));
    send_access(MODE_SPARE, line_addr(48'd4, 1, 48'd7));
    send_access(MODE_LOAD, line_addr(48'd1, 1, 48'd9));
    send_access(MODE_LOAD, line_addr(48'd5, 1, 48'd0));
    send_access(MODE_STORE, line_addr(48'd2, 1, 48'd0));
    send_access(MODE_MODIFY, line_addr(48'd1, 1, 48'd1));
    send_access(MODE_LOAD, line_addr(48'd4, 1, 48'd2));
    finish_burst();
  endtask

  task automatic test_config_extremes();
    set_geometry(5'd31, 5'd31, 5'd7);
    send_access(MODE_LOAD, '1);
    send_access(MODE_STORE, '0);
    send_access(MODE_MODIFY, 48'h8000_0000_0000);
    finish_burst();
    cfg_write(REG_SPARE, 5'd21);
    set_geometry(5'd6, 5'd16, 5'd0);
    send_access(MODE_LOAD, '1);
    send_access(MODE_STORE, 48'h0000_FFFF_0000);
    send_access(MODE_LOAD, 48'h0000_0001_FFFF);
    finish_burst();
  endtask

  task automatic test_geometry_change();
    set_geometry(5'd1, 5'd2, 5'd4);
    for (int t = 1; t <= 4; t++) send_access(MODE_LOAD, line_addr(48'(t), 1, 48'd0));
    finish_burst();
    set_geometry(5'd0, 5'd2, 5'd2);
    send_access(MODE_LOAD, line_addr(48'd3, 0, 48'd1));
    send_access(MODE_STORE, line_addr(48'd6, 0, 48'd0));
    send_access(MODE_MODIFY, line_addr(48'd4, 0, 48'd2));
    finish_burst();
  endtask

  task automatic run_traffic(int count);
    logic [ADDR_W-1:0] pool [16];
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] off_mask;
    int pool_n;
    int set_top;
    pool_n = $urandom_range(16, 3);
    set_top = ((1 << eff_set_bits()) > 4) ? 3 : (1 << eff_set_bits()) - 1;
    off_mask = (48'd1 << block_bits_r) - 1;
    for (int i = 0; i < pool_n; i++)
      pool[i] = line_addr(rand_addr(), $urandom_range(set_top), '0);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 5)
        pool[$urandom_range(pool_n - 1)] = line_addr(rand_addr(), $urandom_range(set_top), '0);
      if ($urandom_range(99) < 85)
        addr = pool[$urandom_range(pool_n - 1)] | (rand_addr() & off_mask);
      else
        addr = rand_addr();
      send_access(MODE_W'($urandom_range(3)), addr);
    end
    finish_burst();
  endtask

  task automatic test_backpressure();
    set_geometry(5'd3, 5'd5, 5'd4);
    hold_left = 300;
    run_traffic(40);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      calm = (p == 3);
      set_geometry(DATA_W'($urandom_range(31)),
                   ($urandom_range(9) == 0) ? DATA_W'($urandom_range(31, 17))
                                            : DATA_W'($urandom_range(16)),
                   DATA_W'($urandom_range(31)));
      run_traffic(100);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    acc_ch.valid <= 1'b0;
    acc_ch.word <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.word <= '0;
    calm = 1'b0;
    hold_left = 0;
    failures = 0;
    n_items = 0;
    n_hit = 0;
    n_fill = 0;
    n_evict = 0;
    n_cfg = 0;
    reset_shadow();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_lru_order();
    test_config_extremes();
    test_geometry_change();
    test_backpressure();
    test_random_traffic();

    repeat (8) @(posedge clk);
    $display("Ran %0d accesses: %0d hits, %0d fills, %0d evictions; %0d register writes",
             n_items, n_hit, n_fill, n_evict, n_cfg);
    $display("Covered default, extreme and random geometries, LRU order and a held-off sink");
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", failures);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
